// ===== hdl/modbus_write_multiple_frame_check_assert.svh =====
// Assertion macros for the write-multiple frame checker
`ifndef MODBUS_WRITE_MULTIPLE_FRAME_CHECK_ASSERT_SVH
`define MODBUS_WRITE_MULTIPLE_FRAME_CHECK_ASSERT_SVH

// clocked assertion, disabled while reset is applied
`define MWFC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked assertion, checked during reset as well
`define MWFC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/mwfc_pkg.sv =====
// Package for the write-multiple frame checker: constants, types, CRC step
package mwfc_pkg;

	localparam int MAX_FRAME_BYTES_DEF = 256;
	localparam int CNT_W = 9;
	localparam int HDR_LEN = 6;
	localparam int BYTECOUNT_POS = 6;
	localparam int FRAME_OVERHEAD = 9;
	localparam int REPLY_LEN = 8;
	localparam int IDX_W = 3;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_BAD   = 2'd2
	} status_t;

	typedef struct packed {
		logic [HDR_LEN-1:0][7:0] hdr;
		logic [15:0]             hcrc;
		logic [15:0]             crc;
		logic [CNT_W-1:0]        len;
		logic [7:0]              decl;
		logic                    ovr;
	} job_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== hdl/modbus_write_multiple_frame_check.sv =====
// Modbus RTU write-multiple-registers request checker, top level
//
//   channel  | valid        | ready        | payload
//   ---------+--------------+--------------+-------------------------------------------
//   request  | data_valid   | data_ready   | data_byte, frame_end
//   reply    | reply_valid  | reply_ready  | reply_byte, reply_last, status, start_addr, reg_count
//
// One request byte per cycle; CRC and header capture run in the accumulator in that cycle.
// A finished frame sits in a one-entry frame register and is judged there; the reply
// register then issues 8 bytes (good frame) or 1 status, one per cycle the sink takes.
// Bytes of the next frame keep flowing meanwhile; only its last byte waits while the frame
// register holds a frame whose final item has not yet been loaded into the reply register.
// Reset clears the accumulator and control state; the frame register and reply data are not reset.
module modbus_write_multiple_frame_check #(
	parameter int MaxFrameBytes = mwfc_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_ready,
	input  logic [7:0]  data_byte,
	input  logic        frame_end,
	output logic        reply_valid,
	input  logic        reply_ready,
	output logic [7:0]  reply_byte,
	output logic        reply_last,
	output logic [1:0]  status,
	output logic [15:0] start_addr,
	output logic [15:0] reg_count
);

	mwfc_pkg::job_t                job_next;
	mwfc_pkg::job_t                job_s1;
	logic                          job_valid_s1;
	logic [mwfc_pkg::IDX_W-1:0]    idx_q;
	logic                          accept;
	logic                          out_load;
	logic                          job_release;
	mwfc_pkg::status_t             st;
	logic [15:0]                   start_w;
	logic [15:0]                   count_w;
	logic [17:0]                   need_len;
	logic [7:0]                    byte_w;
	logic                          last_w;
	logic                          reply_valid_q;
	logic [7:0]                    reply_byte_q;
	logic                          reply_last_q;
	logic [1:0]                    status_q;
	logic [15:0]                   start_addr_q;
	logic [15:0]                   reg_count_q;

	assign accept = data_valid && data_ready;

	mwfc_frame_acc #(
		.MaxFrameBytes(MaxFrameBytes)
	) u_acc (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.data_byte(data_byte),
		.frame_end(frame_end),
		.job_next (job_next)
	);

	assign start_w  = {job_s1.hdr[2], job_s1.hdr[3]};
	assign count_w  = {job_s1.hdr[4], job_s1.hdr[5]};
	assign need_len = 18'(mwfc_pkg::FRAME_OVERHEAD) + 18'({count_w, 1'b0});

	always_comb begin
		priority if (job_s1.ovr) begin
			st = mwfc_pkg::ST_BAD;
		end else if (18'(job_s1.len) < need_len) begin
			st = mwfc_pkg::ST_SHORT;
		end else if ((job_s1.len != mwfc_pkg::CNT_W'(mwfc_pkg::FRAME_OVERHEAD)
				+ mwfc_pkg::CNT_W'(job_s1.decl))
				|| (17'(job_s1.decl) != {count_w, 1'b0})
				|| (job_s1.crc != 16'h0000)) begin
			st = mwfc_pkg::ST_BAD;
		end else begin
			st = mwfc_pkg::ST_OK;
		end
	end

	always_comb begin
		unique case (idx_q)
			3'd0:    byte_w = job_s1.hdr[0];
			3'd1:    byte_w = job_s1.hdr[1];
			3'd2:    byte_w = job_s1.hdr[2];
			3'd3:    byte_w = job_s1.hdr[3];
			3'd4:    byte_w = job_s1.hdr[4];
			3'd5:    byte_w = job_s1.hdr[5];
			3'd6:    byte_w = job_s1.hcrc[7:0];
			default: byte_w = job_s1.hcrc[15:8];
		endcase
	end

	assign last_w      = (st != mwfc_pkg::ST_OK)
		|| (idx_q == mwfc_pkg::IDX_W'(mwfc_pkg::REPLY_LEN - 1));
	assign out_load    = job_valid_s1 && (!reply_valid_q || reply_ready);
	assign job_release = out_load && last_w;
	assign data_ready  = !frame_end || !job_valid_s1 || job_release;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
			idx_q        <= '0;
		end else begin
			if (accept && frame_end) begin
				job_valid_s1 <= 1'b1;
			end else if (job_release) begin
				job_valid_s1 <= 1'b0;
			end
			if (job_release) begin
				idx_q <= '0;
			end else if (out_load) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && frame_end) begin
			job_s1 <= job_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reply_valid_q <= 1'b0;
		end else if (out_load) begin
			reply_valid_q <= 1'b1;
		end else if (reply_ready) begin
			reply_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			reply_byte_q <= (st == mwfc_pkg::ST_OK) ? byte_w : 8'h00;
			reply_last_q <= last_w;
			status_q     <= st;
			start_addr_q <= start_w;
			reg_count_q  <= count_w;
		end
	end

	assign reply_valid = reply_valid_q;
	assign reply_byte  = reply_byte_q;
	assign reply_last  = reply_last_q;
	assign status      = status_q;
	assign start_addr  = start_addr_q;
	assign reg_count   = reg_count_q;

endmodule

// ===== hdl/mwfc_frame_acc.sv =====
// Per-frame accumulator: byte count, running CRC, header, header CRC, byte count field and overflow
module mwfc_frame_acc #(
	parameter int MaxFrameBytes = mwfc_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    data_byte,
	input  logic          frame_end,
	output mwfc_pkg::job_t job_next
);

	logic [mwfc_pkg::CNT_W-1:0]             cnt_q;
	logic [15:0]                            crc_q;
	logic [mwfc_pkg::HDR_LEN-1:0][7:0]      hdr_q;
	logic [15:0]                            hcrc_q;
	logic [7:0]                             decl_q;
	logic                                   ovr_q;
	logic [15:0]                            crc_new;

	assign crc_new = mwfc_pkg::crc_feed(crc_q, data_byte);

	always_comb begin
		job_next.hdr  = hdr_q;
		job_next.hcrc = hcrc_q;
		job_next.crc  = crc_q;
		job_next.len  = cnt_q;
		job_next.decl = decl_q;
		job_next.ovr  = ovr_q;
		if (cnt_q < mwfc_pkg::CNT_W'(MaxFrameBytes)) begin
			if (cnt_q < mwfc_pkg::CNT_W'(mwfc_pkg::HDR_LEN)) begin
				job_next.hdr[cnt_q[mwfc_pkg::IDX_W-1:0]] = data_byte;
			end
			if (cnt_q == mwfc_pkg::CNT_W'(mwfc_pkg::BYTECOUNT_POS)) begin
				job_next.decl = data_byte;
			end
			job_next.crc = crc_new;
			if (cnt_q == mwfc_pkg::CNT_W'(mwfc_pkg::HDR_LEN - 1)) begin
				job_next.hcrc = crc_new;
			end
			job_next.len = cnt_q + 1'b1;
		end else begin
			job_next.ovr = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			crc_q  <= mwfc_pkg::CRC_INIT;
			hdr_q  <= '0;
			hcrc_q <= mwfc_pkg::CRC_INIT;
			decl_q <= '0;
			ovr_q  <= 1'b0;
		end else if (accept) begin
			if (frame_end) begin
				cnt_q  <= '0;
				crc_q  <= mwfc_pkg::CRC_INIT;
				hdr_q  <= '0;
				hcrc_q <= mwfc_pkg::CRC_INIT;
				decl_q <= '0;
				ovr_q  <= 1'b0;
			end else begin
				cnt_q  <= job_next.len;
				crc_q  <= job_next.crc;
				hdr_q  <= job_next.hdr;
				hcrc_q <= job_next.hcrc;
				decl_q <= job_next.decl;
				ovr_q  <= job_next.ovr;
			end
		end
	end

endmodule

// ===== hdl/mwfc_checker.sv =====
// Port-level assertion checker for the frame checker, with its bind
`include "modbus_write_multiple_frame_check_assert.svh"

module mwfc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        data_valid,
	input logic        data_ready,
	input logic        frame_end,
	input logic        reply_valid,
	input logic        reply_ready,
	input logic [7:0]  reply_byte,
	input logic        reply_last,
	input logic [1:0]  status
);

	`MWFC_ASSERT(a_reply_hold, reply_valid && !reply_ready |=> reply_valid && $stable(reply_byte) && $stable(status), "reply dropped or changed while stalled")
	`MWFC_ASSERT(a_status_single, reply_valid && (status != mwfc_pkg::ST_OK) |-> reply_last && (reply_byte == 8'h00), "status result not a single zero item")
	`MWFC_ASSERT(a_mid_reply_good, reply_valid && !reply_last |-> (status == mwfc_pkg::ST_OK), "non-final item carries an error status")
	`MWFC_ASSERT_ALWAYS(a_body_ready, data_valid && !frame_end |-> data_ready, "frame body byte stalled")

endmodule

bind modbus_write_multiple_frame_check mwfc_checker u_mwfc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.data_valid (data_valid),
	.data_ready (data_ready),
	.frame_end  (frame_end),
	.reply_valid(reply_valid),
	.reply_ready(reply_ready),
	.reply_byte (reply_byte),
	.reply_last (reply_last),
	.status     (status)
);

// ===== verif/modbus_write_multiple_frame_check_test.sv =====
// Testbench for the Modbus write-multiple request checker: frame traffic vs a scoreboard
`timescale 1ns / 1ps

module modbus_write_multiple_frame_check_test;

	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int RANDOM_ITEMS = 260;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [7:0] FC_WRITE_MULTIPLE = 8'h10;

	typedef struct {
		logic [7:0]          rbyte;
		logic                last;
		mwfc_pkg::status_t   st;
		logic [15:0]         start;
		logic [15:0]         count;
	} reply_t;

	typedef enum int {
		FK_GOOD,
		FK_CORRUPT,
		FK_BAD_DECL,
		FK_EXTRA,
		FK_TRUNC,
		FK_NOISE
	} frame_kind_t;

	class frame_reply_model;
		int unsigned nbytes;
		logic [15:0] crc;
		logic [15:0] hcrc;
		logic [7:0]  hdr[mwfc_pkg::HDR_LEN];
		logic [7:0]  decl;
		bit          ovr;
		reply_t      pending_replies[$];
		int          mismatches;
		int          n_good;
		int          n_short;
		int          n_bad;

		function new();
			clear();
		endfunction

		static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
			logic [15:0] r;
			r = c ^ {8'h00, b};
			repeat (8) r = {1'b0, r[15:1]} ^ (r[0] ? mwfc_pkg::CRC_POLY : 16'h0000);
			return r;
		endfunction

		function void clear();
			nbytes = 0;
			crc = mwfc_pkg::CRC_INIT;
			hcrc = mwfc_pkg::CRC_INIT;
			foreach (hdr[i]) hdr[i] = 8'h00;
			decl = 8'h00;
			ovr = 0;
		endfunction

		function void take_byte(logic [7:0] b, logic fend);
			logic [15:0] start;
			logic [15:0] count;
			int unsigned need;
			mwfc_pkg::status_t st;
			reply_t r;
			if (nbytes < mwfc_pkg::MAX_FRAME_BYTES_DEF) begin
				if (nbytes < mwfc_pkg::HDR_LEN) hdr[nbytes] = b;
				if (nbytes == mwfc_pkg::BYTECOUNT_POS) decl = b;
				crc = crc_step(crc, b);
				if (nbytes == mwfc_pkg::HDR_LEN - 1) hcrc = crc;
				nbytes++;
			end else begin
				ovr = 1;
			end
			if (!fend) return;
			start = {hdr[2], hdr[3]};
			count = {hdr[4], hdr[5]};
			need = mwfc_pkg::FRAME_OVERHEAD + 2 * count;
			if (ovr)
				st = mwfc_pkg::ST_BAD;
			else if (nbytes < need)
				st = mwfc_pkg::ST_SHORT;
			else if (nbytes != mwfc_pkg::FRAME_OVERHEAD + decl || decl != 2 * count
					|| crc != 16'h0000)
				st = mwfc_pkg::ST_BAD;
			else
				st = mwfc_pkg::ST_OK;
			r.st = st;
			r.start = start;
			r.count = count;
			if (st != mwfc_pkg::ST_OK) begin
				r.rbyte = 8'h00;
				r.last = 1'b1;
				pending_replies.push_back(r);
				if (st == mwfc_pkg::ST_SHORT) n_short++;
				else n_bad++;
			end else begin
				for (int k = 0; k < mwfc_pkg::REPLY_LEN; k++) begin
					r.rbyte = (k < mwfc_pkg::HDR_LEN) ? hdr[k]
						: (k == mwfc_pkg::HDR_LEN) ? hcrc[7:0] : hcrc[15:8];
					r.last = (k == mwfc_pkg::REPLY_LEN - 1);
					pending_replies.push_back(r);
				end
				n_good++;
			end
			clear();
		endfunction

		function void match_reply(logic [7:0] rb, logic rl, logic [1:0] rs,
				logic [15:0] rst, logic [15:0] rct);
			reply_t e;
			if (pending_replies.size() == 0) begin
				$error("reply transaction with nothing pending: byte %0h status %0d", rb, rs);
				mismatches++;
				return;
			end
			e = pending_replies.pop_front();
			if (rb !== e.rbyte) begin
				$error("reply_byte: expected %0h, got %0h", e.rbyte, rb);
				mismatches++;
			end
			if (rl !== e.last) begin
				$error("reply_last: expected %0b, got %0b", e.last, rl);
				mismatches++;
			end
			if (rs !== e.st) begin
				$error("status: expected %0d, got %0d", e.st, rs);
				mismatches++;
			end
			if (rst !== e.start) begin
				$error("start_addr: expected %0h, got %0h", e.start, rst);
				mismatches++;
			end
			if (rct !== e.count) begin
				$error("reg_count: expected %0h, got %0h", e.count, rct);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        data_valid = 1'b0;
	logic        data_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        frame_end = 1'b0;
	logic        reply_valid;
	logic        reply_ready = 1'b0;
	logic [7:0]  reply_byte;
	logic        reply_last;
	logic [1:0]  status;
	logic [15:0] start_addr;
	logic [15:0] reg_count;

	frame_reply_model model = new();
	logic [7:0] frame_q[$];
	int cycle_count = 0;
	int items_sent = 0;
	int frames_sent = 0;

	modbus_write_multiple_frame_check dut (
		.clk(clk),
		.arst_n(arst_n),
		.data_valid(data_valid),
		.data_ready(data_ready),
		.data_byte(data_byte),
		.frame_end(frame_end),
		.reply_valid(reply_valid),
		.reply_ready(reply_ready),
		.reply_byte(reply_byte),
		.reply_last(reply_last),
		.status(status),
		.start_addr(start_addr),
		.reg_count(reg_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("modbus_write_multiple_frame_check_test: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (data_valid && data_ready) model.take_byte(data_byte, frame_end);
			if (reply_valid && reply_ready)
				model.match_reply(reply_byte, reply_last, status, start_addr, reg_count);
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// header, byte count and register data, no CRC yet
	task automatic make_body(logic [7:0] addr, logic [7:0] fc, logic [15:0] start,
			logic [15:0] n);
		logic [15:0] nb;
		nb = 2 * n;
		frame_q = {};
		frame_q.push_back(addr);
		frame_q.push_back(fc);
		frame_q.push_back(start[15:8]);
		frame_q.push_back(start[7:0]);
		frame_q.push_back(n[15:8]);
		frame_q.push_back(n[7:0]);
		frame_q.push_back(nb[7:0]);
		repeat (nb) frame_q.push_back(8'($urandom));
	endtask

	task automatic seal_frame();
		logic [15:0] c;
		c = mwfc_pkg::CRC_INIT;
		foreach (frame_q[i]) c = frame_reply_model::crc_step(c, frame_q[i]);
		frame_q.push_back(c[7:0]);
		frame_q.push_back(c[15:8]);
	endtask

	task automatic send_byte(logic [7:0] b, logic fend, int gap);
		data_valid <= 1'b1;
		data_byte <= b;
		frame_end <= fend;
		do @(posedge clk); while (!data_ready);
		if (gap > 0) begin
			data_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_frame(bit steady);
		int last;
		last = frame_q.size() - 1;
		for (int i = 0; i <= last; i++)
			send_byte(frame_q[i], i == last, steady ? 0 : pick_gap());
		items_sent += frame_q.size();
		frames_sent++;
	endtask

	// sink: long hold-off first so the request side backs up, then random stalls
	initial begin
		wait (arst_n);
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		forever begin
			reply_ready <= 1'b1;
			if ($urandom_range(0, 9) == 0) repeat ($urandom_range(60, 150)) @(posedge clk);
			else repeat ($urandom_range(1, 12)) @(posedge clk);
			if (pick_gap() > 0) begin
				reply_ready <= 1'b0;
				repeat (pick_gap() + 1) @(posedge clk);
			end
		end
	end

	initial begin
		int random_items;
		int r;
		int idx;
		int extra;
		bit max_good_done;
		bit overrun_done;
		logic [15:0] n;
		logic [7:0] fc;
		frame_kind_t kind;

		random_items = 0;
		max_good_done = 0;
		overrun_done = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames, sent back to back, starting during the sink hold-off
		frame_q = {8'hFF, FC_WRITE_MULTIPLE, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h02, 8'h00, 8'hFF};
		seal_frame();
		send_frame(1);
		frame_q = {8'h5A};
		send_frame(1);
		make_body(8'h00, FC_WRITE_MULTIPLE, 16'h0000, 16'h0000);
		seal_frame();
		frame_q[8] = frame_q[8] ^ 8'h01;
		send_frame(1);
		frame_q = {8'h01, FC_WRITE_MULTIPLE, 8'h00};
		send_frame(1);

		while (random_items < RANDOM_ITEMS) begin
			if (!max_good_done && random_items >= 90) begin
				make_body(8'($urandom), FC_WRITE_MULTIPLE, 16'($urandom), 16'd123);
				seal_frame();
				send_frame($urandom_range(0, 1));
				max_good_done = 1;
			end else if (!overrun_done && random_items >= 180) begin
				make_body(8'($urandom), FC_WRITE_MULTIPLE, 16'($urandom), 16'd123);
				seal_frame();
				repeat ($urandom_range(2, 5)) frame_q.push_back(8'($urandom));
				send_frame($urandom_range(0, 1));
				overrun_done = 1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 45) kind = FK_GOOD;
				else if (r < 55) kind = FK_CORRUPT;
				else if (r < 63) kind = FK_BAD_DECL;
				else if (r < 71) kind = FK_EXTRA;
				else if (r < 84) kind = FK_TRUNC;
				else kind = FK_NOISE;
				n = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(7, 20))
						: 16'($urandom_range(0, 6));
				fc = ($urandom_range(0, 7) == 0) ? 8'($urandom) : FC_WRITE_MULTIPLE;
				make_body(8'($urandom), fc, 16'($urandom), n);
				case (kind)
					FK_GOOD: begin
						seal_frame();
					end
					FK_CORRUPT: begin
						seal_frame();
						idx = $urandom_range(0, frame_q.size() - 1);
						frame_q[idx] = frame_q[idx] ^ 8'(1 << $urandom_range(0, 7));
					end
					FK_BAD_DECL: begin
						extra = $urandom_range(1, 4);
						frame_q[mwfc_pkg::BYTECOUNT_POS] =
							frame_q[mwfc_pkg::BYTECOUNT_POS] + 8'(extra);
						repeat (extra) frame_q.push_back(8'($urandom));
						seal_frame();
					end
					FK_EXTRA: begin
						repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom));
						seal_frame();
					end
					FK_TRUNC: begin
						seal_frame();
						repeat ($urandom_range(1, frame_q.size() - 1)) void'(frame_q.pop_back());
					end
					default: begin
						frame_q = {};
						repeat ($urandom_range(1, 20)) frame_q.push_back(8'($urandom));
					end
				endcase
				random_items += frame_q.size();
				send_frame($urandom_range(0, 3) == 0);
			end
		end
		data_valid <= 1'b0;

		while (model.pending_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d request bytes in %0d frames, incl. a max-size good frame and an overrun",
				items_sent, frames_sent);
		$display("judged frames: %0d good, %0d too short, %0d bad",
				model.n_good, model.n_short, model.n_bad);
		if (model.mismatches == 0 && model.pending_replies.size() == 0) begin
			$display("modbus_write_multiple_frame_check_test: done, clean");
		end else begin
			$display("modbus_write_multiple_frame_check_test: done, errors");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/mwfc_pkg.sv
hdl/mwfc_frame_acc.sv
hdl/modbus_write_multiple_frame_check.sv
hdl/mwfc_checker.sv
verif/modbus_write_multiple_frame_check_test.sv
